@@ src/dsw_pkg.sv @@
// ----------------------------------------------------------------------------
// dsw_pkg: shared types and constants of the dice sum way counter
// Item types, default sizes and the control structs that pass between the
// sequencer and the accumulate datapath.
// ----------------------------------------------------------------------------
package dsw_pkg;

  // Default sizes, handed to the top level parameters
  localparam int MaxDiceDef   = 64;
  localparam int MaxFacesDef  = 64;
  localparam int MaxTargetDef = 1023;

  // Field widths fixed by the item format
  localparam int DiceW   = 7;
  localparam int FacesW  = 7;
  localparam int TargetW = 10;
  localparam int WaysW   = 64;

  typedef struct packed {
    logic [DiceW-1:0]   dice;
    logic [FacesW-1:0]  faces;
    logic [TargetW-1:0] target;
  } dsw_in_t;

  typedef struct packed {
    logic [WaysW-1:0] ways;
    logic             overflow;
  } dsw_out_t;

  // Tag that travels with each row read, aligned with the memory read data
  typedef struct packed {
    logic vld;    // a term is being read
    logic first;  // first term of an entry
    logic last;   // last term of an entry
    logic zero;   // read address (entry minus term) is zero
    logic row1;   // first row: previous row is the unit row
    logic sel;    // which row memory is read
    logic fin;    // term belongs to the answer entry
  } dsw_tag_t;

  // Finished answer from the datapath
  typedef struct packed {
    logic             done;
    logic [WaysW-1:0] ways;
    logic             overflow;
  } dsw_res_t;

endpackage

@@ src/dsw_ram.sv @@
// ----------------------------------------------------------------------------
// dsw_ram: generic single write, single read memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module dsw_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/dsw_acc.sv @@
// ----------------------------------------------------------------------------
// dsw_acc: saturating accumulate datapath
// Sums the previous row's terms for one entry, saturates at the maximum,
// writes the finished entry back and reports the answer entry.
// ----------------------------------------------------------------------------
module dsw_acc (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     clr_i,
  input  dsw_pkg::dsw_tag_t        tag_i,
  input  logic [dsw_pkg::WaysW-1:0] rdata0_i,
  input  logic [dsw_pkg::WaysW-1:0] rdata1_i,
  output logic                     we0_o,
  output logic                     we1_o,
  output logic [dsw_pkg::WaysW-1:0] wdata_o,
  output dsw_pkg::dsw_res_t        res_o
);

  logic [dsw_pkg::WaysW-1:0] acc_q;
  logic                      ovf_q;
  logic [dsw_pkg::WaysW-1:0] ram_data;
  logic [dsw_pkg::WaysW-1:0] term;
  logic [dsw_pkg::WaysW-1:0] base;
  logic [dsw_pkg::WaysW:0]   sum;
  logic [dsw_pkg::WaysW-1:0] sat;

  // Term: unit row in the first row, zero at index zero, else the row memory
  always_comb begin
    ram_data = tag_i.sel ? rdata1_i : rdata0_i;
    if (tag_i.zero) begin
      term = dsw_pkg::WaysW'(tag_i.row1);
    end else if (tag_i.row1) begin
      term = '0;
    end else begin
      term = ram_data;
    end
    base = tag_i.first ? '0 : acc_q;
    sum  = {1'b0, base} + {1'b0, term};
    sat  = sum[dsw_pkg::WaysW] ? '1 : sum[dsw_pkg::WaysW-1:0];
  end

  // Hold the running sum and the sticky overflow
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      if (clr_i) begin
        ovf_q <= 1'b0;
      end else if (tag_i.vld && sum[dsw_pkg::WaysW]) begin
        ovf_q <= 1'b1;
      end
      if (tag_i.vld) begin
        acc_q <= sat;
      end
    end
  end

  // Write the finished entry into the row memory not being read
  assign we0_o   = tag_i.vld && tag_i.last && tag_i.sel;
  assign we1_o   = tag_i.vld && tag_i.last && !tag_i.sel;
  assign wdata_o = sat;

  assign res_o.done     = tag_i.vld && tag_i.last && tag_i.fin;
  assign res_o.ways     = sat;
  assign res_o.overflow = ovf_q || sum[dsw_pkg::WaysW];

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(we0_o && we1_o))
    else $error("both row memories written at once");

  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q && !clr_i |=> ovf_q)
    else $error("overflow flag dropped within an item");

endmodule

@@ src/dsw_seq.sv @@
// ----------------------------------------------------------------------------
// dsw_seq: row, entry and term sequencer
// Takes an item, walks rows, entries and terms issuing one row memory read
// per cycle, and holds the answer in the output register.
// ----------------------------------------------------------------------------
module dsw_seq #(
  parameter int MaxDice   = dsw_pkg::MaxDiceDef,
  parameter int MaxFaces  = dsw_pkg::MaxFacesDef,
  parameter int MaxTarget = dsw_pkg::MaxTargetDef,
  localparam int AddrW = (MaxTarget + 1 > 1) ? $clog2(MaxTarget + 1) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  dsw_pkg::dsw_in_t     in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output dsw_pkg::dsw_out_t    out_item_o,
  output logic                 clr_o,
  output logic [AddrW-1:0]     raddr_o,
  output logic [AddrW-1:0]     waddr_o,
  output dsw_pkg::dsw_tag_t    tag_o,
  input  dsw_pkg::dsw_res_t    res_i
);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_WAIT, ST_DONE} state_e;

  state_e                       state_q;
  logic [dsw_pkg::DiceW-1:0]    dice_q;
  logic [dsw_pkg::FacesW-1:0]   faces_q;
  logic [AddrW-1:0]             tgt_q;
  logic [dsw_pkg::DiceW-1:0]    row_q;
  logic [AddrW-1:0]             s_q;
  logic [AddrW-1:0]             s_wr_q;
  logic [dsw_pkg::FacesW-1:0]   i_q;
  dsw_pkg::dsw_tag_t            tag_d;
  dsw_pkg::dsw_tag_t            tag_q;
  dsw_pkg::dsw_out_t            res_q;
  dsw_pkg::dsw_out_t            out_q;
  logic                         out_vld_q;
  logic                         out_load;
  logic [31:0]                  tgt_ext;
  logic [31:0]                  diff;
  logic                         in_bad;
  logic                         in_imm;
  logic                         in_one;

  // Decode the incoming item
  always_comb begin
    tgt_ext = 32'(in_item_i.target);
    in_bad  = (32'(in_item_i.dice) > 32'(MaxDice)) ||
              (32'(in_item_i.faces) > 32'(MaxFaces)) ||
              (tgt_ext > 32'(MaxTarget));
    in_one  = !in_bad && (in_item_i.dice == '0) && (in_item_i.target == '0);
    in_imm  = in_bad || (in_item_i.dice == '0) || (in_item_i.target == '0) ||
              (in_item_i.faces == '0);
  end

  // Build the read address and the tag of the term issued this cycle
  always_comb begin
    diff        = 32'(s_q) - 32'(i_q);
    raddr_o     = diff[AddrW-1:0];
    tag_d.vld   = (state_q == ST_RUN);
    tag_d.first = (i_q == dsw_pkg::FacesW'(1));
    tag_d.last  = (i_q == faces_q) || (32'(i_q) == 32'(s_q));
    tag_d.zero  = (32'(i_q) == 32'(s_q));
    tag_d.row1  = (row_q == dsw_pkg::DiceW'(1));
    tag_d.sel   = !row_q[0];
    tag_d.fin   = (row_q == dice_q) && (s_q == tgt_q);
  end

  // Load the output register once it is free or being taken
  assign out_load = (state_q == ST_DONE) && (!out_vld_q || out_ready_i);

  // Hold state, counters and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
      tag_q     <= '0;
    end else begin
      tag_q  <= tag_d;
      s_wr_q <= s_q;
      if (out_load) begin
        out_q     <= res_q;
        out_vld_q <= 1'b1;
      end else if (out_vld_q && out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            dice_q  <= in_item_i.dice;
            faces_q <= in_item_i.faces;
            tgt_q   <= tgt_ext[AddrW-1:0];
            row_q   <= dsw_pkg::DiceW'(1);
            s_q     <= AddrW'(1);
            i_q     <= dsw_pkg::FacesW'(1);
            if (in_imm) begin
              res_q.ways     <= dsw_pkg::WaysW'(in_one);
              res_q.overflow <= 1'b0;
              state_q        <= ST_DONE;
            end else begin
              state_q <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          // Advance term, then entry, then row
          if (!tag_d.last) begin
            i_q <= i_q + dsw_pkg::FacesW'(1);
          end else begin
            i_q <= dsw_pkg::FacesW'(1);
            if (s_q != tgt_q) begin
              s_q <= s_q + AddrW'(1);
            end else begin
              s_q <= AddrW'(1);
              if (row_q == dice_q) begin
                state_q <= ST_WAIT;
              end else begin
                row_q <= row_q + dsw_pkg::DiceW'(1);
              end
            end
          end
        end
        ST_WAIT: begin
          // Catch the answer entry as it leaves the accumulator
          res_q.ways     <= res_i.ways;
          res_q.overflow <= res_i.overflow;
          state_q        <= ST_DONE;
        end
        ST_DONE: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign clr_o       = in_valid_i && (state_q == ST_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;
  assign tag_o       = tag_q;
  assign waddr_o     = s_wr_q;

  a_tag_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag_q.vld |-> $past(state_q == ST_RUN))
    else $error("row read issued outside a computation");

  a_term_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> (i_q != '0) && (i_q <= faces_q) &&
      (32'(i_q) <= 32'(s_q)) && (s_q <= tgt_q) && (s_q != '0))
    else $error("term or entry counter out of range");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_i.done |-> state_q == ST_WAIT)
    else $error("answer entry finished at the wrong time");

endmodule

@@ src/dice_sum_way_counter_core.sv @@
// ----------------------------------------------------------------------------
// dice_sum_way_counter_core: ordered dice outcome counter
// Counts the ordered ways a number of dice can show a target sum by building
// the rows of the dynamic programme in two ping-pong row memories.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i/in_ready_o   in_item_i  (dice, faces, target)
//   out      output     out_valid_o/out_ready_i out_item_o (ways, overflow)
//
// After accepting an item the sequencer sums min(faces, s) terms for each entry
// s=1..target of each of the dice rows, one term per cycle through the single
// read port of the row memory, then catches the answer entry and loads the
// output register. Items with zero dice, target or faces or an out of range
// field go straight to the output register. A full output register that is
// not being taken stalls the sequencer and keeps the input not ready.
// The row memories need no clearing after reset: every entry whose read data
// is used in an item is written earlier in that item.
// ----------------------------------------------------------------------------
module dice_sum_way_counter_core #(
  parameter int MaxDice   = dsw_pkg::MaxDiceDef,
  parameter int MaxFaces  = dsw_pkg::MaxFacesDef,
  parameter int MaxTarget = dsw_pkg::MaxTargetDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dsw_pkg::dsw_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dsw_pkg::dsw_out_t out_item_o
);

  localparam int Depth = MaxTarget + 1;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic                      clr;
  logic [AddrW-1:0]          raddr;
  logic [AddrW-1:0]          waddr;
  dsw_pkg::dsw_tag_t         tag;
  dsw_pkg::dsw_res_t         res;
  logic                      we0;
  logic                      we1;
  logic [dsw_pkg::WaysW-1:0] wdata;
  logic [dsw_pkg::WaysW-1:0] rdata0;
  logic [dsw_pkg::WaysW-1:0] rdata1;

  // Sequence rows, entries and terms
  dsw_seq #(
    .MaxDice  (MaxDice),
    .MaxFaces (MaxFaces),
    .MaxTarget(MaxTarget)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .clr_o      (clr),
    .raddr_o    (raddr),
    .waddr_o    (waddr),
    .tag_o      (tag),
    .res_i      (res)
  );

  // Ping-pong row memories
  dsw_ram #(
    .Width(dsw_pkg::WaysW),
    .Depth(Depth)
  ) u_row0 (
    .clk_i  (clk_i),
    .we_i   (we0),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata0)
  );

  dsw_ram #(
    .Width(dsw_pkg::WaysW),
    .Depth(Depth)
  ) u_row1 (
    .clk_i  (clk_i),
    .we_i   (we1),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata1)
  );

  // Sum terms and write entries back
  dsw_acc u_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (clr),
    .tag_i   (tag),
    .rdata0_i(rdata0),
    .rdata1_i(rdata1),
    .we0_o   (we0),
    .we1_o   (we1),
    .wdata_o (wdata),
    .res_o   (res)
  );

endmodule
